// ===== rtl/iee_pkg.sv =====
// Shared types, character codes and a helper function for the infix expression evaluator.
// Used by iee_datapath, iee_ctrl, the top module and the bench; it depends on nothing else.
`default_nettype none

package iee_pkg;

    localparam int DEF_VALUE_DEPTH    = 16;
    localparam int DEF_OPERATOR_DEPTH = 16;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_UNDER    = 2'd2;
    localparam logic [1:0] ST_OVER     = 2'd3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       final_char;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_CLASS, S_LOOP, S_OPCHK, S_RED, S_RDA, S_EXEC,
        S_DIV, S_RET, S_END, S_FCLOSE, S_FLOOP, S_FTOP, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        MODE_CLOSE, MODE_OTHER, MODE_FINAL
    } t_mode;

    typedef struct packed {
        logic load_char;
        logic digit;
        logic close_num;
        logic push_op;
        logic rd_op;
        logic pop_op;
        logic rd_b;
        logic latch_b;
        logic rd_a;
        logic set_err1;
        logic set_err2;
        logic write_alu;
        logic div_start;
        logic write_div;
        logic rd_top;
        logic load_out;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic is_digit;
        logic is_space;
        logic is_lparen;
        logic is_rparen;
        logic num_open;
        logic err_set;
        logic op_empty;
        logic val_lt2;
        logic val_empty;
        logic top_is_lparen;
        logic top_ge_rank;
        logic top_is_div;
        logic b_zero;
        logic div_done;
        logic last;
        logic out_busy;
    } t_stat;

    function automatic logic [1:0] rank_of(input logic [7:0] c);
        logic [1:0] r;
        r = 2'd0;
        if (c == CH_PLUS || c == CH_MINUS) r = 2'd1;
        if (c == CH_STAR || c == CH_SLASH) r = 2'd2;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/iee_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the value stack and the operator stack.
`default_nettype none

module iee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/iee_div.sv =====
// Iterative 32-bit signed divider, one quotient bit per cycle, truncating.
// Depends on nothing but its ports; instantiated by iee_datapath.
`default_nettype none

module iee_div (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [31:0] i_dividend,
    input  wire  [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic [31:0] r_quo;
    logic [31:0] r_div;
    logic [32:0] r_rem;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_neg;
    logic        r_done;

    logic [32:0] rem_sh;
    logic [32:0] trial;

    assign rem_sh = {r_rem[31:0], r_quo[31]};
    assign trial  = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
            r_div <= i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;
            r_neg <= i_dividend[31] ^ i_divisor[31];
        end else if (r_busy) begin
            if (!trial[32]) begin
                r_rem <= trial;
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (32'd0 - r_quo) : r_quo;

endmodule

`default_nettype wire

// ===== rtl/iee_datapath.sv =====
// Datapath of the evaluator: stack memories, counters, pending number, ALU, divider
// and the output register. Depends on iee_pkg, iee_ram and iee_div.
`default_nettype none

module iee_datapath
    import iee_pkg::*;
#(
    parameter int VALUE_DEPTH    = DEF_VALUE_DEPTH,
    parameter int OPERATOR_DEPTH = DEF_OPERATOR_DEPTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_cmd       i_cmd,
    input  t_in_word   i_in_word,
    input  wire        i_out_stall,
    output t_stat      o_stat,
    output logic       o_out_valid,
    output t_out_word  o_out_word
);

    localparam int VAW = $clog2(VALUE_DEPTH);
    localparam int VCW = $clog2(VALUE_DEPTH + 1);
    localparam int OAW = $clog2(OPERATOR_DEPTH);
    localparam int OCW = $clog2(OPERATOR_DEPTH + 1);

    logic [VCW-1:0] r_vcount;
    logic [OCW-1:0] r_ocount;
    logic [31:0]    r_pending;
    logic           r_open;
    logic [1:0]     r_err;
    logic [7:0]     r_char;
    logic           r_last;
    logic [31:0]    r_b;
    logic           r_out_valid;
    t_out_word      r_out_word;

    logic [VCW-1:0] vcm1, vcm2;
    logic [OCW-1:0] ocm1;
    logic           v_full, o_full;

    logic           v_we, v_re;
    logic [VAW-1:0] v_waddr, v_raddr;
    logic [31:0]    v_wdata, v_rdata;
    logic           o_we;
    logic [7:0]     o_rdata;

    logic [31:0]    alu;
    logic           div_done;
    logic [31:0]    div_q;

    assign vcm1   = r_vcount - VCW'(1);
    assign vcm2   = r_vcount - VCW'(2);
    assign ocm1   = r_ocount - OCW'(1);
    assign v_full = r_vcount >= VCW'(VALUE_DEPTH);
    assign o_full = r_ocount >= OCW'(OPERATOR_DEPTH);

    always_comb begin
        case (o_rdata)
            CH_PLUS:  alu = v_rdata + r_b;
            CH_MINUS: alu = v_rdata - r_b;
            CH_STAR:  alu = v_rdata * r_b;
            default:  alu = 32'd0;
        endcase
    end

    always_comb begin
        v_we    = i_cmd.close_num && !v_full;
        v_waddr = r_vcount[VAW-1:0];
        v_wdata = r_pending;
        if (i_cmd.write_alu || i_cmd.write_div) begin
            v_we    = 1'b1;
            v_waddr = vcm2[VAW-1:0];
            v_wdata = i_cmd.write_div ? div_q : alu;
        end
        v_re    = i_cmd.rd_b || i_cmd.rd_a || i_cmd.rd_top;
        v_raddr = i_cmd.rd_a ? vcm2[VAW-1:0] : vcm1[VAW-1:0];
    end

    assign o_we = i_cmd.push_op && !o_full;

    iee_ram #(.WIDTH(32), .DEPTH(VALUE_DEPTH)) u_vram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_re    (v_re),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    iee_ram #(.WIDTH(8), .DEPTH(OPERATOR_DEPTH)) u_oram (
        .i_clk   (i_clk),
        .i_we    (o_we),
        .i_waddr (r_ocount[OAW-1:0]),
        .i_wdata (r_char),
        .i_re    (i_cmd.rd_op),
        .i_raddr (ocm1[OAW-1:0]),
        .o_rdata (o_rdata)
    );

    // The dividend is the lower stack value, which is on the read port during EXEC.
    iee_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (v_rdata),
        .i_divisor  (r_b),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_char) begin
            r_char <= i_in_word.char_code;
            r_last <= i_in_word.final_char;
        end
        if (i_cmd.latch_b) begin
            r_b <= v_rdata;
        end
        if (i_cmd.load_out) begin
            r_out_word.status <= r_err;
            r_out_word.value  <= (r_err != ST_OK) ? 32'sd0 : $signed(v_rdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount    <= '0;
            r_ocount    <= '0;
            r_pending   <= '0;
            r_open      <= 1'b0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.digit) begin
                r_pending <= (r_pending << 3) + (r_pending << 1)
                           + {24'd0, r_char - CH_ZERO};
                r_open    <= 1'b1;
            end
            if (i_cmd.close_num) begin
                r_pending <= '0;
                r_open    <= 1'b0;
                if (v_full) begin
                    if (r_err == ST_OK) r_err <= ST_OVER;
                end else begin
                    r_vcount <= r_vcount + VCW'(1);
                end
            end
            if (i_cmd.push_op) begin
                if (o_full) begin
                    if (r_err == ST_OK) r_err <= ST_OVER;
                end else begin
                    r_ocount <= r_ocount + OCW'(1);
                end
            end
            if (i_cmd.pop_op) begin
                r_ocount <= ocm1;
            end
            if (i_cmd.set_err1 && r_err == ST_OK) begin
                r_err <= ST_DIV_ZERO;
            end
            if (i_cmd.set_err2 && r_err == ST_OK) begin
                r_err <= ST_UNDER;
            end
            if (i_cmd.write_alu || i_cmd.write_div) begin
                r_vcount <= vcm1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_vcount  <= '0;
                r_ocount  <= '0;
                r_pending <= '0;
                r_open    <= 1'b0;
                r_err     <= ST_OK;
            end
        end
    end

    always_comb begin
        o_stat.is_digit      = (r_char >= CH_ZERO) && (r_char <= CH_NINE);
        o_stat.is_space      = r_char == CH_SPACE;
        o_stat.is_lparen     = r_char == CH_LPAREN;
        o_stat.is_rparen     = r_char == CH_RPAREN;
        o_stat.num_open      = r_open;
        o_stat.err_set       = r_err != ST_OK;
        o_stat.op_empty      = r_ocount == '0;
        o_stat.val_lt2       = r_vcount < VCW'(2);
        o_stat.val_empty     = r_vcount == '0;
        o_stat.top_is_lparen = o_rdata == CH_LPAREN;
        o_stat.top_ge_rank   = rank_of(o_rdata) >= rank_of(r_char);
        o_stat.top_is_div    = o_rdata == CH_SLASH;
        o_stat.b_zero        = r_b == 32'd0;
        o_stat.div_done      = div_done;
        o_stat.last          = r_last;
        o_stat.out_busy      = r_out_valid && i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_vcount == '0) && (r_ocount == '0))
        else $error("stack counts not cleared after a result");

    a_vcount_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcount <= VCW'(VALUE_DEPTH))
        else $error("value count beyond stack depth");

    a_reduce_has_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.write_alu || i_cmd.write_div) |-> r_vcount >= VCW'(2))
        else $error("reduction written with fewer than two values");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> !(r_out_valid && i_out_stall))
        else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

// ===== rtl/iee_ctrl.sv =====
// Controller state machine of the evaluator: sequences character handling,
// reductions and the final result. Depends on iee_pkg.
`default_nettype none

module iee_ctrl
    import iee_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_OTHER;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_stat.err_set || i_stat.is_digit) n_state = S_END;
                else n_state = S_CLASS;
            end
            S_CLASS: begin
                if (i_stat.err_set || i_stat.is_space || i_stat.is_lparen) begin
                    n_state = S_END;
                end else begin
                    n_state = S_LOOP;
                    n_mode  = i_stat.is_rparen ? MODE_CLOSE : MODE_OTHER;
                end
            end
            S_LOOP: begin
                if (i_stat.err_set || i_stat.op_empty) n_state = S_END;
                else n_state = S_OPCHK;
            end
            S_OPCHK: begin
                case (r_mode)
                    MODE_CLOSE: n_state = i_stat.top_is_lparen ? S_END : S_RED;
                    MODE_OTHER: n_state = i_stat.top_ge_rank ? S_RED : S_END;
                    default:    n_state = S_RED;
                endcase
            end
            S_RED: begin
                n_state = i_stat.val_lt2 ? S_RET : S_RDA;
            end
            S_RDA: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = (i_stat.top_is_div && !i_stat.b_zero) ? S_DIV : S_RET;
            end
            S_DIV: begin
                if (i_stat.div_done) n_state = S_RET;
            end
            S_RET: begin
                n_state = (r_mode == MODE_FINAL) ? S_FLOOP : S_LOOP;
            end
            S_END: begin
                n_state = i_stat.last ? S_FCLOSE : S_IDLE;
            end
            S_FCLOSE: begin
                n_state = S_FLOOP;
                n_mode  = MODE_FINAL;
            end
            S_FLOOP: begin
                if (i_stat.err_set || i_stat.op_empty) n_state = S_FTOP;
                else n_state = S_OPCHK;
            end
            S_FTOP: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_char = i_in_valid;
            end
            S_DECODE: begin
                if (!i_stat.err_set) begin
                    o_cmd.digit     = i_stat.is_digit;
                    o_cmd.close_num = !i_stat.is_digit && i_stat.num_open;
                end
            end
            S_CLASS: begin
                o_cmd.push_op = !i_stat.err_set && i_stat.is_lparen;
            end
            S_LOOP: begin
                if (!i_stat.err_set) begin
                    o_cmd.push_op = i_stat.op_empty && r_mode == MODE_OTHER;
                    o_cmd.rd_op   = !i_stat.op_empty;
                end
            end
            S_OPCHK: begin
                case (r_mode)
                    MODE_CLOSE: o_cmd.pop_op  = i_stat.top_is_lparen;
                    MODE_OTHER: o_cmd.push_op = !i_stat.top_ge_rank;
                    default:    o_cmd.push_op = 1'b0;
                endcase
            end
            S_RED: begin
                o_cmd.set_err2 = i_stat.val_lt2;
                o_cmd.rd_b     = !i_stat.val_lt2;
            end
            S_RDA: begin
                o_cmd.latch_b = 1'b1;
                o_cmd.rd_a    = 1'b1;
            end
            S_EXEC: begin
                o_cmd.pop_op = 1'b1;
                if (i_stat.top_is_div) begin
                    o_cmd.set_err1  = i_stat.b_zero;
                    o_cmd.div_start = !i_stat.b_zero;
                end else begin
                    o_cmd.write_alu = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.write_div = i_stat.div_done;
            end
            S_FCLOSE: begin
                o_cmd.close_num = !i_stat.err_set && i_stat.num_open;
            end
            S_FLOOP: begin
                o_cmd.rd_op = !i_stat.err_set && !i_stat.op_empty;
            end
            S_FTOP: begin
                if (!i_stat.err_set) begin
                    o_cmd.set_err2 = i_stat.val_empty;
                    o_cmd.rd_top   = !i_stat.val_empty;
                end
            end
            S_OUT: begin
                o_cmd.load_out = !i_stat.out_busy;
                o_cmd.clear    = !i_stat.out_busy;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule

`default_nettype wire

// ===== rtl/infix_expression_evaluator.sv =====
// Infix expression evaluator: one character per word in, one result word per expression.
// A digit extends the pending number, a space is skipped and '(' is pushed; an operator or ')'
// first runs its reductions, and a reduction that divides yields one quotient bit a cycle.
// The final word closes any number, reduces the rest and waits while a result is stalled.
// One word is in work at a time; a result waits in the output register while the next
// expression streams in. Synchronous active-low reset empties both stacks and drops results.
`default_nettype none

module infix_expression_evaluator
    import iee_pkg::*;
#(
    parameter int VALUE_DEPTH    = DEF_VALUE_DEPTH,
    parameter int OPERATOR_DEPTH = DEF_OPERATOR_DEPTH
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  wire       i_out_stall,
    output t_out_word o_out_word
);

    t_cmd  cmd;
    t_stat stat;

    iee_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    iee_datapath #(
        .VALUE_DEPTH    (VALUE_DEPTH),
        .OPERATOR_DEPTH (OPERATOR_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

// ===== bench/iee_checker.sv =====
// Checker for the infix expression evaluator: watches both channels, predicts each
// result word with its own two-stack evaluator and compares. Depends on iee_pkg.
`default_nettype none

module iee_checker
    import iee_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    input  wire       i_in_stall,
    input  t_in_word  i_in_word,
    input  wire       i_out_valid,
    input  wire       i_out_stall,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int DEPTH = DEF_VALUE_DEPTH;

    logic [31:0] vals [DEPTH];
    logic [7:0]  ops [DEPTH];
    int          nvals;
    int          nops;
    logic [31:0] number;
    logic        number_open;
    logic [1:0]  err;
    t_out_word   results_due [$];

    function automatic int prec(input logic [7:0] c);
        if (c == CH_PLUS || c == CH_MINUS) return 1;
        if (c == CH_STAR || c == CH_SLASH) return 2;
        return 0;
    endfunction

    function automatic void clear_expr();
        nvals = 0;
        nops = 0;
        number = 0;
        number_open = 0;
        err = ST_OK;
    endfunction

    function automatic void push_val(input logic [31:0] v);
        if (nvals >= DEPTH) err = ST_OVER;
        else begin
            vals[nvals] = v;
            nvals++;
        end
    endfunction

    function automatic void push_op(input logic [7:0] c);
        if (nops >= DEPTH) err = ST_OVER;
        else begin
            ops[nops] = c;
            nops++;
        end
    endfunction

    function automatic void reduce();
        logic signed [31:0] a, b;
        logic signed [31:0] r;
        logic [7:0] op;
        if (nops == 0) return;
        if (nvals < 2) begin
            err = ST_UNDER;
            return;
        end
        b = vals[nvals-1];
        a = vals[nvals-2];
        op = ops[nops-1];
        nops--;
        r = 0;
        if (op == CH_PLUS) r = a + b;
        else if (op == CH_MINUS) r = a - b;
        else if (op == CH_STAR) r = a * b;
        else if (op == CH_SLASH) begin
            if (b == 0) begin
                err = ST_DIV_ZERO;
                return;
            end
            if (a == 32'sh8000_0000 && b == -1) r = a;
            else r = a / b;
        end
        nvals -= 2;
        vals[nvals] = r;
        nvals++;
    endfunction

    function automatic void close_num();
        if (number_open) begin
            push_val(number);
            number = 0;
            number_open = 0;
        end
    endfunction

    function automatic void take_char(input logic [7:0] c);
        int r;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            number = number * 10 + 32'(c - CH_ZERO);
            number_open = 1;
            return;
        end
        close_num();
        if (err != ST_OK || c == CH_SPACE) return;
        if (c == CH_LPAREN) push_op(c);
        else if (c == CH_RPAREN) begin
            while (err == ST_OK && nops > 0 && ops[nops-1] != CH_LPAREN) reduce();
            if (err == ST_OK && nops > 0) nops--;
        end else begin
            r = prec(c);
            while (err == ST_OK && nops > 0 && prec(ops[nops-1]) >= r) reduce();
            if (err == ST_OK) push_op(c);
        end
    endfunction

    function automatic void evaluate(input t_in_word w);
        t_out_word res;
        if (err == ST_OK) take_char(w.char_code);
        if (!w.final_char) return;
        if (err == ST_OK) close_num();
        while (err == ST_OK && nops > 0) reduce();
        if (err == ST_OK && nvals == 0) err = ST_UNDER;
        res.value = (err == ST_OK) ? vals[nvals-1] : 32'sd0;
        res.status = err;
        results_due.push_back(res);
        clear_expr();
    endfunction

    initial begin
        clear_expr();
        o_fail_count = 0;
    end

    assign o_pending = results_due.size();

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            clear_expr();
            results_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall) evaluate(i_in_word);
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result word value=%0d status=%0d",
                                 i_out_word.value, i_out_word.status);
                end else begin
                    want = results_due.pop_front();
                    if (want.value !== i_out_word.value ||
                        want.status !== i_out_word.status) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                                     want.value, want.status,
                                     i_out_word.value, i_out_word.status);
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_infix_expression_evaluator.sv =====
// Top of the infix expression evaluator testbench: clock, reset, stimulus and verdict.
// Depends on iee_pkg, the block and iee_checker.
`default_nettype none

module tb_infix_expression_evaluator;
    import iee_pkg::*;

    logic      clk = 0;
    logic      rst_n = 0;
    logic      in_valid = 0;
    logic      in_stall;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_stall = 0;
    t_out_word out_word;
    int        fails;
    int        pending;
    int        cycles = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    logic [7:0] chars [$];
    logic       finals [$];

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    infix_expression_evaluator dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_word(out_word)
    );

    iee_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_word(in_word),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_word(out_word),
        .o_fail_count(fails), .o_pending(pending)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Queues one expression; the last character carries the final mark.
    task automatic add_expr(input string s);
        for (int i = 0; i < s.len(); i++) begin
            chars.push_back(s[i]);
            finals.push_back(i == s.len() - 1);
        end
    endtask

    task automatic send_all();
        while (chars.size() > 0) begin
            if ($urandom_range(99) < send_idle_pct) begin
                in_valid <= 0;
                @(posedge clk);
            end else begin
                in_valid <= 1;
                in_word.char_code <= chars.pop_front();
                in_word.final_char <= finals.pop_front();
                @(posedge clk);
                while (in_stall) @(posedge clk);
            end
        end
        in_valid <= 0;
    endtask

    function automatic string rand_num();
        case ($urandom_range(3))
            0: return "0";
            1: return $sformatf("%0d", $urandom_range(9));
            2: return $sformatf("%0d", $urandom_range(99999));
            default: return $sformatf("%0d", $urandom);
        endcase
    endfunction

    function automatic string rand_op();
        case ($urandom_range(3))
            0: return "+";
            1: return "-";
            2: return "*";
            default: return "/";
        endcase
    endfunction

    // Mostly well-formed expressions with random content, sometimes nested.
    function automatic string rand_expr(input int lvl);
        string s;
        int n;
        n = $urandom_range(3);
        s = ($urandom_range(3) == 0 && lvl < 3) ? {"(", rand_expr(lvl + 1), ")"} : rand_num();
        for (int i = 0; i < n; i++) begin
            s = {s, ($urandom_range(2) == 0) ? " " : "", rand_op()};
            s = {s, ($urandom_range(3) == 0 && lvl < 3) ? {"(", rand_expr(lvl + 1), ")"}
                                                       : rand_num()};
        end
        return s;
    endfunction

    function automatic string noise_expr();
        string s;
        int n;
        s = "";
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(1)) s = {s, string'(8'($urandom_range(255)))};
            else s = {s, rand_op()};
        end
        return s;
    endfunction

    task automatic random_phase(input int idle, input int stall, input int nchars);
        int start;
        send_idle_pct = idle;
        stall_pct = stall;
        start = chars.size();
        while (chars.size() - start < nchars) begin
            if ($urandom_range(9) < 8) add_expr(rand_expr(0));
            else add_expr(noise_expr());
        end
        send_all();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // Directed: operators, precedence, spaces, wrapping, division corners, errors.
        add_expr("1+2*3");
        add_expr("(1+2)*3 ");
        add_expr("7 - 10/3");
        add_expr("-7/2");
        add_expr("0-2147483648/-1");
        add_expr("(0-2147483647-1)/(0-1)");
        add_expr("4294967295*3");
        add_expr("99999999999");
        add_expr("2147483647+1");
        add_expr("5/0");
        add_expr("+");
        add_expr(" ");
        add_expr("((3)");
        add_expr("3)");
        add_expr("1 2 3");
        add_expr("2a3");
        add_expr("1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1");
        add_expr("((((((((((((((((((1");
        add_expr("1 2 3 4 5 6 7 8 9 1 2 3 4 5 6 7 8");
        add_expr({"9", string'(8'hFF), "1"});
        send_all();
        // Hold off until every result has come back.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        random_phase(0, 0, 310);
        random_phase(68, 0, 310);
        random_phase(0, 68, 310);
        random_phase(16, 16, 310);
        stall_pct = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
